// File: sv/assert_macros.svh
// Assertion helpers shared by the packer RTL.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and disabled while reset is asserted (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dfhbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhbp_pkg
// Types, code constants and the length and distance tables of the packer.
// ----------------------------------------------------------------------------
package dfhbp_pkg;

    localparam int BITS_W          = 18;  // longest token: 5 code bits + 13 extra
    localparam int CNT_W           = 5;   // holds counts up to 25
    localparam int ACC_W           = 25;  // 7 pending bits + 18 new bits
    localparam int MAX_RAW_BITS    = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [2:0] OP_SYMBOL   = 3'd0;
    localparam logic [2:0] OP_LENGTH   = 3'd1;
    localparam logic [2:0] OP_DISTANCE = 3'd2;
    localparam logic [2:0] OP_RAW      = 3'd3;
    localparam logic [2:0] OP_FLUSH    = 3'd4;

    // Fixed literal/length code ranges.
    localparam logic [15:0] SYM_LIT_END  = 16'd144;
    localparam logic [15:0] SYM_EOB      = 16'd256;
    localparam logic [15:0] SYM_LEN_MID  = 16'd280;
    localparam logic [15:0] SYM_END      = 16'd288;
    localparam logic [15:0] SYM_LEN_BASE = 16'd257;
    localparam logic [15:0] LEN_MIN      = 16'd3;
    localparam logic [15:0] LEN_MAX      = 16'd258;
    localparam logic [15:0] DIST_MIN     = 16'd1;
    localparam logic [15:0] DIST_MAX     = 16'd32768;

    localparam logic [8:0] LEN_BASE [29] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15,
        9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67,
        9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_EXTRA [29] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_BASE [30] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17,
        16'd25, 16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257,
        16'd385, 16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073,
        16'd4097, 16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_EXTRA [30] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4,
        4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9,
        4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] value;
        logic [4:0]  bit_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // One classified token: bits in send order (first bit in bit 0).
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [CNT_W-1:0]  count;
        logic              flush;
    } t_entry;

endpackage

// File: sv/dfhbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhbp_front
// Turns one token into a run of bits in send order plus a flush flag.
// ----------------------------------------------------------------------------
module dfhbp_front (
    input  dfhbp_pkg::t_in_item i_item,
    output dfhbp_pkg::t_entry   o_entry
);
    import dfhbp_pkg::*;

    typedef struct packed {
        logic [8:0] bits;
        logic [3:0] len;
    } t_sym;

    // Fixed Huffman code of a symbol, reversed so the MSB goes out first.
    function automatic t_sym sym_code(input logic [15:0] s);
        logic [8:0] code;
        logic [3:0] n;
        t_sym       r;
        code = '0;
        n    = '0;
        if (s < SYM_LIT_END) begin
            code = 9'(16'h30 + s);
            n    = 4'd8;
        end else if (s < SYM_EOB) begin
            code = 9'(16'h190 + (s - SYM_LIT_END));
            n    = 4'd9;
        end else if (s < SYM_LEN_MID) begin
            code = 9'(s - SYM_EOB);
            n    = 4'd7;
        end else if (s < SYM_END) begin
            code = 9'(16'hC0 + (s - SYM_LEN_MID));
            n    = 4'd8;
        end
        r.bits = '0;
        for (int i = 0; i < 9; i++) begin
            if (i < int'(n)) begin
                r.bits[i] = code[int'(n) - 1 - i];
            end
        end
        r.len = n;
        return r;
    endfunction

    function automatic logic [BITS_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [BITS_W-1:0] m;
        for (int i = 0; i < BITS_W; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    logic [4:0]        len_idx;
    logic [4:0]        dist_idx;
    logic [8:0]        len_diff;
    logic [15:0]       dist_diff;
    t_sym              sym_direct;
    t_sym              sym_len;
    logic [4:0]        dist_rev;
    logic [CNT_W-1:0]  raw_cnt;

    always_comb begin
        len_idx  = '0;
        dist_idx = '0;
        for (int i = 0; i < 29; i++) begin
            if (16'(LEN_BASE[i]) <= i_item.value) begin
                len_idx = 5'(i);
            end
        end
        for (int i = 0; i < 30; i++) begin
            if (DIST_BASE[i] <= i_item.value) begin
                dist_idx = 5'(i);
            end
        end
        len_diff   = i_item.value[8:0] - LEN_BASE[len_idx];
        dist_diff  = i_item.value - DIST_BASE[dist_idx];
        sym_direct = sym_code(i_item.value);
        sym_len    = sym_code(SYM_LEN_BASE + 16'(len_idx));
        for (int i = 0; i < 5; i++) begin
            dist_rev[i] = dist_idx[4 - i];
        end
        raw_cnt = (i_item.bit_count > CNT_W'(MAX_RAW_BITS)) ?
                  CNT_W'(MAX_RAW_BITS) : i_item.bit_count;
    end

    always_comb begin
        o_entry = '0;
        case (i_item.op)
            OP_SYMBOL: begin
                o_entry.bits  = BITS_W'(sym_direct.bits);
                o_entry.count = CNT_W'(sym_direct.len);
            end
            OP_LENGTH: begin
                if (i_item.value >= LEN_MIN && i_item.value <= LEN_MAX) begin
                    o_entry.bits  = BITS_W'(sym_len.bits) |
                                    (BITS_W'(len_diff) << sym_len.len);
                    o_entry.count = CNT_W'(sym_len.len) + CNT_W'(LEN_EXTRA[len_idx]);
                end
            end
            OP_DISTANCE: begin
                if (i_item.value >= DIST_MIN && i_item.value <= DIST_MAX) begin
                    o_entry.bits  = BITS_W'(dist_rev) | (BITS_W'(dist_diff) << 5);
                    o_entry.count = CNT_W'(5) + CNT_W'(DIST_EXTRA[dist_idx]);
                end
            end
            OP_RAW: begin
                o_entry.bits  = BITS_W'(i_item.value) & low_mask(raw_cnt);
                o_entry.count = raw_cnt;
            end
            OP_FLUSH: begin
                o_entry.flush = 1'b1;
            end
            default: begin
                o_entry = '0;
            end
        endcase
    end

endmodule

// File: sv/dfhbp_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dfhbp_queue
// Short register queue of classified tokens between front and back.
// ----------------------------------------------------------------------------
module dfhbp_queue #(
    parameter int DEPTH = dfhbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dfhbp_pkg::t_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    output dfhbp_pkg::t_entry o_entry,
    input  logic              i_pop
);
    import dfhbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_Q-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_Q'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_Q'(DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "push lost")

endmodule

// File: sv/dfhbp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dfhbp_back
// Bit accumulator: merges queued tokens, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module dfhbp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  dfhbp_pkg::t_entry    i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_empty,
    output dfhbp_pkg::t_out_item o_item,
    input  logic                 i_pop
);
    import dfhbp_pkg::*;

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_flush, n_flush;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [ACC_W-1:0] cur_acc;
    logic [CNT_W-1:0] cur_cnt;
    logic             cur_flush;
    logic             load;
    logic             emit;
    logic             can_out;

    // A token is merged only once every whole byte of the previous one is out.
    always_comb begin
        load = i_q_valid && (r_cnt < CNT_W'(8)) && !(r_flush && r_cnt != '0);
        if (load) begin
            cur_acc   = ACC_W'(r_acc[7:0]) | (ACC_W'(i_q_entry.bits) << r_cnt[2:0]);
            cur_cnt   = r_cnt + i_q_entry.count;
            cur_flush = i_q_entry.flush;
        end else begin
            cur_acc   = r_acc;
            cur_cnt   = r_cnt;
            cur_flush = r_flush;
        end
        can_out = !r_out_valid || i_pop;
        emit    = can_out && ((cur_cnt >= CNT_W'(8)) || (cur_flush && cur_cnt != '0));
    end

    always_comb begin
        n_acc       = cur_acc;
        n_cnt       = cur_cnt;
        n_flush     = cur_flush;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        if (emit) begin
            n_acc          = cur_acc >> 8;
            n_cnt          = (cur_cnt >= CNT_W'(8)) ? cur_cnt - CNT_W'(8) : '0;
            n_out_valid    = 1'b1;
            n_out.out_byte = cur_acc[7:0];
            n_out.last     = (cur_cnt < CNT_W'(16));
        end
    end

    assign o_q_pop = load;
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    `ASSERT_ALWAYS(a_acc_clean, i_clk, i_rst_n, (r_acc >> r_cnt) == '0, "bits above count")
    `ASSERT_ALWAYS(a_flush_short, i_clk, i_rst_n, !(r_flush && r_cnt != '0) || r_cnt < CNT_W'(8), "flush too long")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_pop, r_out_valid && $stable(r_out), "byte dropped")

endmodule

// File: sv/deflate_fixed_huffman_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_bit_packer
// Deflate back end: fixed Huffman coding and LSB-first byte packing.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload        Transfers when
//  -------   ---------------------  -------------  --------------------
//  token     push in / full out     i_in_item      push && !full
//  byte      empty out / pop in     o_out_item     pop && !empty
//
//  Each token is classified in the cycle it is taken and enters a short queue.
//  The back end takes one queued token per cycle once the previous token's
//  whole bytes are out, and sends one byte per cycle while the byte side is
//  not stalled, the first in the cycle of the merge. Reset is synchronous
//  and active low; it clears the queue, the pending bits and the output
//  valid flag. A stalled byte holds in the output register while the queue
//  keeps taking tokens until it fills.
//
module deflate_fixed_huffman_bit_packer #(
    parameter int QUEUE_DEPTH = dfhbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  dfhbp_pkg::t_in_item  i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output dfhbp_pkg::t_out_item o_out_item
);
    import dfhbp_pkg::*;

    // Classified token headed for the queue, and the queue head.
    t_entry front_entry;
    t_entry q_entry;
    logic   q_valid;
    logic   q_pop;

    // The front end is pure decode: a symbol turns into its reversed Huffman
    // code, a length into its length symbol plus extra bits, a distance into
    // its five code bits plus extra bits, and raw bits are masked to the
    // clamped count. Invalid tokens become entries that write nothing.
    dfhbp_front u_front (
        .i_item  (i_in_item),
        .o_entry (front_entry)
    );

    // The queue decouples classification from packing so a stall at the byte
    // side does not stop tokens from coming in right away.
    dfhbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (q_pop)
    );

    // The back end keeps the partial byte and its bit count between tokens,
    // merges each token's bits above them, and flags the final byte that a
    // token causes as last.
    dfhbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_item    (o_out_item),
        .i_pop     (pop)
    );

endmodule
